// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define HDRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HDRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HDRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HDRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define HDRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define HDRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/hdrc_pkg.sv -----
// ----------------------------------------------------------------------------
// hdrc_pkg
// Types, codes and helpers of the hook debounce and ring controller.
// ----------------------------------------------------------------------------
package hdrc_pkg;

    localparam int CNT_W   = 16;
    localparam int OVR_W   = 24;
    localparam int MODE_W  = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FORCE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR_OVR = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_EN     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSUME_ON   = 8'd3;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [CNT_W-1:0] HALF_PERIOD_RST = 16'd25;
    localparam logic [CNT_W-1:0] CNT_MAX         = '1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hook_level;
        logic              forced_off_hook;
        logic              override_on;
        logic [OVR_W-1:0]  override_ticks;
    } cmd_t;

    typedef struct packed {
        logic off_hook;
        logic hook_changed;
        logic ring_mode;
        logic ring_polarity;
        logic override_active;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic [CNT_W-1:0] debounce_ms;
        logic [CNT_W-1:0] ring_half_period_ms;
        logic             ring_enable;
        logic             assume_on_hook;
    } cfg_t;

    typedef struct packed {
        logic             hook_state;
        logic             last_sample;
        logic [CNT_W-1:0] stable_count;
        logic             ringing;
        logic             ring_level;
        logic [CNT_W-1:0] ring_count;
        logic             override_flag;
        logic             override_timed;
        logic [OVR_W-1:0] override_left;
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

// ----- src/hdrc_stream_if.sv -----
// ----------------------------------------------------------------------------
// hdrc_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface hdrc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/hdrc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hdrc_cfg_regs
// Configuration register file written through the config channel.
// ----------------------------------------------------------------------------
module hdrc_cfg_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    hdrc_stream_if.sink           cfg,
    output hdrc_pkg::cfg_t        cfg_q
);

    hdrc_pkg::cfg_t cfg_reg;
    hdrc_pkg::cfg_t cfg_next;
    hdrc_pkg::cfg_write_t wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.payload;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (wr.index)
                hdrc_pkg::CFG_DEBOUNCE:    cfg_next.debounce_ms         = wr.data;
                hdrc_pkg::CFG_HALF_PERIOD: cfg_next.ring_half_period_ms = wr.data;
                hdrc_pkg::CFG_RING_EN:     cfg_next.ring_enable         = wr.data[0];
                hdrc_pkg::CFG_ASSUME_ON:   cfg_next.assume_on_hook      = wr.data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms         <= hdrc_pkg::DEBOUNCE_RST;
            cfg_reg.ring_half_period_ms <= hdrc_pkg::HALF_PERIOD_RST;
            cfg_reg.ring_enable         <= 1'b1;
            cfg_reg.assume_on_hook      <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/hdrc_step.sv -----
// ----------------------------------------------------------------------------
// hdrc_step
// Next-state logic for one command or tick beat.
// ----------------------------------------------------------------------------
module hdrc_step (
    input  hdrc_pkg::state_t st,
    input  hdrc_pkg::cfg_t   cfg,
    input  hdrc_pkg::cmd_t   cmd,
    output hdrc_pkg::state_t st_next,
    output logic             changed
);

    always_comb
    begin
        hdrc_pkg::state_t s;
        logic             chg;
        logic             sample;

        s      = st;
        chg    = 1'b0;
        sample = cfg.assume_on_hook ? 1'b0 : cmd.hook_level;

        case (cmd.mode)
            hdrc_pkg::MODE_TICK:
            begin
                // run down a timed override, then hand the hook back to the input
                if (s.override_flag && s.override_timed)
                begin
                    if (s.override_left != '0)
                        s.override_left = s.override_left - 1'b1;
                    if (s.override_left == '0)
                    begin
                        s.override_flag  = 1'b0;
                        s.override_timed = 1'b0;
                        if (cmd.hook_level != s.hook_state)
                        begin
                            s.hook_state = cmd.hook_level;
                            chg = 1'b1;
                            if (s.hook_state)
                            begin
                                s.ringing    = 1'b0;
                                s.ring_level = 1'b0;
                            end
                        end
                    end
                end
                // debounce
                if (!s.override_flag && sample != s.last_sample)
                begin
                    s.last_sample  = sample;
                    s.stable_count = '0;
                end
                else
                begin
                    s.stable_count = hdrc_pkg::sat_inc(s.stable_count);
                end
                if (!s.override_flag && s.stable_count > cfg.debounce_ms &&
                    sample != s.hook_state)
                begin
                    s.override_timed = 1'b0;
                    s.override_left  = '0;
                    s.hook_state     = sample;
                    chg = 1'b1;
                    if (s.hook_state)
                    begin
                        s.ringing    = 1'b0;
                        s.ring_level = 1'b0;
                    end
                end
                // ring cadence
                if (s.ringing)
                begin
                    if (s.hook_state)
                    begin
                        s.ringing    = 1'b0;
                        s.ring_level = 1'b0;
                    end
                    else
                    begin
                        s.ring_count = hdrc_pkg::sat_inc(s.ring_count);
                        if (s.ring_count >= cfg.ring_half_period_ms)
                        begin
                            s.ring_level = ~s.ring_level;
                            s.ring_count = '0;
                        end
                    end
                end
            end
            hdrc_pkg::MODE_START:
            begin
                if (cfg.ring_enable && !s.ringing && !s.hook_state)
                begin
                    s.ringing    = 1'b1;
                    s.ring_level = 1'b0;
                    s.ring_count = cfg.ring_half_period_ms;
                end
            end
            hdrc_pkg::MODE_STOP:
            begin
                if (cfg.ring_enable && s.ringing)
                begin
                    s.ringing    = 1'b0;
                    s.ring_level = 1'b0;
                end
            end
            hdrc_pkg::MODE_FORCE:
            begin
                s.override_flag  = cmd.override_on;
                s.override_timed = cmd.override_on && (cmd.override_ticks != '0);
                s.override_left  = cmd.override_on ? cmd.override_ticks : '0;
                if (cmd.forced_off_hook != s.hook_state)
                begin
                    s.hook_state = cmd.forced_off_hook;
                    chg = 1'b1;
                    if (s.hook_state)
                    begin
                        s.ringing    = 1'b0;
                        s.ring_level = 1'b0;
                    end
                end
            end
            hdrc_pkg::MODE_CLEAR_OVR:
            begin
                s.override_flag  = 1'b0;
                s.override_timed = 1'b0;
                s.override_left  = '0;
            end
            default:
            begin
                s = st;
            end
        endcase

        st_next = s;
        changed = chg;
    end

endmodule

// ----- src/hook_debounce_ring_control_core.sv -----
// ----------------------------------------------------------------------------
// hook_debounce_ring_control_core: telephone hook debounce and ring control
// Path: a command beat is held in cmd_reg, then its status beat in res_reg.
// Throughput: 1 beat per cycle while status is ready; one state update per beat.
// Reset: on hook, not ringing, no override; registers at their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hook_debounce_ring_control_core (
    input  logic        clk,
    input  logic        rst_n,
    hdrc_stream_if.sink   cmd,
    hdrc_stream_if.source status,
    hdrc_stream_if.sink   cfg
);

    hdrc_pkg::cfg_t    cfg_q;
    hdrc_pkg::cmd_t    cmd_reg;
    logic              cmd_valid_reg;
    logic              cmd_valid_next;
    hdrc_pkg::state_t  st_reg;
    hdrc_pkg::state_t  st_next;
    logic              changed;
    hdrc_pkg::result_t res_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic              advance;
    logic              take;

    hdrc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    hdrc_step u_step (
        .st      (st_reg),
        .cfg     (cfg_q),
        .cmd     (cmd_reg),
        .st_next (st_next),
        .changed (changed)
    );

    assign advance   = cmd_valid_reg && (!res_valid_reg || status.ready);
    assign cmd.ready = !cmd_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    assign status.valid   = res_valid_reg;
    assign status.payload = res_reg;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (take)
            cmd_valid_next = 1'b1;
        else if (advance)
            cmd_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (status.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd.payload;
        if (advance)
        begin
            res_reg.off_hook        <= st_next.hook_state;
            res_reg.hook_changed    <= changed;
            res_reg.ring_mode       <= st_next.ringing;
            res_reg.ring_polarity   <= st_next.ring_level;
            res_reg.override_active <= st_next.override_flag;
        end
    end

    `HDRC_ASSERT(a_no_ring_off_hook, clk, rst_n, !(st_reg.ringing && st_reg.hook_state), "ringing while off hook")
    `HDRC_ASSERT_IMPL(a_level_needs_ring, clk, rst_n, st_reg.ring_level, st_reg.ringing, "ring level set while idle")
    `HDRC_ASSERT_IMPL(a_timed_needs_flag, clk, rst_n, st_reg.override_timed, st_reg.override_flag, "timed override without flag")
    `HDRC_ASSERT_NEXT(a_advance_shows, clk, rst_n, advance, res_valid_reg, "advanced beat not shown")

endmodule

// ----- tb/hook_debounce_ring_control_core_checker.sv -----
// ----------------------------------------------------------------------------
// hook_debounce_ring_control_core_checker
// Watches the command, status and register channels of the hook and ring
// controller, keeps its own copy of the hook, debounce, ring and override
// state, predicts one status beat per command beat and compares each status
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hook_debounce_ring_control_core_checker
    import hdrc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    hdrc_stream_if cmd_mon,
    hdrc_stream_if status_mon,
    hdrc_stream_if cfg_mon,
    output int     errors,
    output int     pending
);

    logic [CNT_W-1:0] debounce_ms;
    logic [CNT_W-1:0] half_period;
    logic             ring_en;
    logic             assume_on;

    logic             hook_q;
    logic             sample_q;
    logic [CNT_W-1:0] stable_cnt;
    logic             ringing_q;
    logic             polarity_q;
    logic [CNT_W-1:0] ring_cnt;
    logic             ovr_q;
    logic             ovr_timed_q;
    logic [OVR_W-1:0] ovr_left;

    result_t status_q[$];

    task automatic silence_ring();
        ringing_q  = 1'b0;
        polarity_q = 1'b0;
    endtask

    task automatic set_hook(input logic lvl, input logic hold, input logic [OVR_W-1:0] span,
                            inout logic chg);
        ovr_q       = hold;
        ovr_timed_q = hold && (span != '0);
        ovr_left    = hold ? span : '0;
        if (lvl != hook_q)
        begin
            hook_q = lvl;
            if (lvl && ringing_q)
                silence_ring();
            chg = 1'b1;
        end
    endtask

    task automatic step_line(input cmd_t c, output result_t r);
        logic chg;
        logic smp;
        chg = 1'b0;
        case (c.mode)
            MODE_TICK:
            begin
                if (ovr_q && ovr_timed_q)
                begin
                    if (ovr_left != '0)
                        ovr_left = ovr_left - 1'b1;
                    if (ovr_left == '0)
                        set_hook(c.hook_level, 1'b0, '0, chg);
                end
                smp = assume_on ? 1'b0 : c.hook_level;
                if (!ovr_q && smp != sample_q)
                begin
                    sample_q   = smp;
                    stable_cnt = '0;
                end
                else if (stable_cnt != '1)
                    stable_cnt = stable_cnt + 1'b1;
                if (!ovr_q && stable_cnt > debounce_ms && smp != hook_q)
                    set_hook(smp, 1'b0, '0, chg);
                if (ringing_q)
                begin
                    if (hook_q)
                        silence_ring();
                    else
                    begin
                        if (ring_cnt != '1)
                            ring_cnt = ring_cnt + 1'b1;
                        if (ring_cnt >= half_period)
                        begin
                            polarity_q = ~polarity_q;
                            ring_cnt   = '0;
                        end
                    end
                end
            end
            MODE_START:
            begin
                if (ring_en && !ringing_q && !hook_q)
                begin
                    ringing_q  = 1'b1;
                    polarity_q = 1'b0;
                    ring_cnt   = half_period;
                end
            end
            MODE_STOP:
            begin
                if (ring_en && ringing_q)
                    silence_ring();
            end
            MODE_FORCE:
                set_hook(c.forced_off_hook, c.override_on, c.override_ticks, chg);
            MODE_CLEAR_OVR:
            begin
                ovr_q       = 1'b0;
                ovr_timed_q = 1'b0;
                ovr_left    = '0;
            end
            default:
            begin
            end
        endcase
        r.off_hook        = hook_q;
        r.hook_changed    = chg;
        r.ring_mode       = ringing_q;
        r.ring_polarity   = polarity_q;
        r.override_active = ovr_q;
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t       c;
        cfg_write_t w;
        result_t    want;
        result_t    got;
        if (!rst_n)
        begin
            debounce_ms = DEBOUNCE_RST;
            half_period = HALF_PERIOD_RST;
            ring_en     = 1'b1;
            assume_on   = 1'b0;
            hook_q      = 1'b0;
            sample_q    = 1'b0;
            stable_cnt  = '0;
            ringing_q   = 1'b0;
            polarity_q  = 1'b0;
            ring_cnt    = '0;
            ovr_q       = 1'b0;
            ovr_timed_q = 1'b0;
            ovr_left    = '0;
            status_q.delete();
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                w = cfg_mon.payload;
                case (w.index)
                    CFG_DEBOUNCE:    debounce_ms = w.data;
                    CFG_HALF_PERIOD: half_period = w.data;
                    CFG_RING_EN:     ring_en     = w.data[0];
                    CFG_ASSUME_ON:   assume_on   = w.data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (status_mon.valid && status_mon.ready)
            begin
                got = status_mon.payload;
                if (status_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: status beat with nothing expected, expected none, actual %b",
                             $time, got);
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("off_hook", want.off_hook, got.off_hook);
                    check_field("hook_changed", want.hook_changed, got.hook_changed);
                    check_field("ring_mode", want.ring_mode, got.ring_mode);
                    check_field("ring_polarity", want.ring_polarity, got.ring_polarity);
                    check_field("override_active", want.override_active, got.override_active);
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                c = cmd_mon.payload;
                step_line(c, want);
                status_q.push_back(want);
            end
            pending = status_q.size();
        end
    end

endmodule

// ----- tb/hook_debounce_ring_control_core_tb.sv -----
// ----------------------------------------------------------------------------
// hook_debounce_ring_control_core_tb
// Drives the hook and ring controller with a directed command sequence and
// then with random tick and command streams under six register settings,
// with random idling on both sides and one long status hold-off. A side
// checker predicts and compares every status beat; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module hook_debounce_ring_control_core_tb;
    import hdrc_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 255;
    localparam int PHASES       = 6;

    localparam logic [CNT_W-1:0] DEB_TAB  [PHASES] = '{16'd0, 16'd3, 16'hFFFF, 16'd2,
                                                        16'd5, 16'd1};
    localparam logic [CNT_W-1:0] HALF_TAB [PHASES] = '{16'd1, 16'd0, 16'hFFFF, 16'd3,
                                                        16'd2, 16'd4};
    localparam logic             EN_TAB   [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam logic             ASM_TAB  [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    logic clk;
    logic rst_n;

    hdrc_stream_if #(.payload_t(cmd_t))       cmd_if ();
    hdrc_stream_if #(.payload_t(result_t))    status_if ();
    hdrc_stream_if #(.payload_t(cfg_write_t)) cfg_if ();

    int   errors;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   quiet       = 0;
    int   stall_left  = 0;
    logic stall_go    = 1'b0;
    logic stall_done  = 1'b0;
    logic line_level  = 1'b0;

    hook_debounce_ring_control_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .status (status_if),
        .cfg    (cfg_if)
    );

    hook_debounce_ring_control_core_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_mon    (cmd_if),
        .status_mon (status_if),
        .cfg_mon    (cfg_if),
        .errors     (errors),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // hold status ready low for a long stretch once, else idle at random
    always @(negedge clk)
    begin
        if (stall_go && !stall_done)
        begin
            stall_done = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            status_if.ready <= 1'b0;
        end
        else
            status_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_if.valid && cmd_if.ready) || (status_if.valid && status_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic cmd_t make_cmd(input logic [MODE_W-1:0] mode, input logic lvl,
                                      input logic forced, input logic hold,
                                      input logic [OVR_W-1:0] span);
        cmd_t c;
        c.mode            = mode;
        c.hook_level      = lvl;
        c.forced_off_hook = forced;
        c.override_on     = hold;
        c.override_ticks  = span;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        int   pick;
        int   span_pick;
        cmd_t c;
        pick = $urandom_range(0, 99);
        c = make_cmd(MODE_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), OVR_W'($urandom));
        if (pick < 68)
        begin
            if ($urandom_range(0, 99) < 12)
                line_level = ~line_level;
            c.mode = MODE_TICK;
            c.hook_level = ($urandom_range(0, 99) < 5) ? ~line_level : line_level;
        end
        else if (pick < 76)
            c.mode = MODE_START;
        else if (pick < 82)
            c.mode = MODE_STOP;
        else if (pick < 90)
        begin
            c.mode = MODE_FORCE;
            span_pick = $urandom_range(0, 99);
            if (span_pick < 65)
                c.override_ticks = OVR_W'($urandom_range(0, 12));
            else if (span_pick < 85)
                c.override_ticks = OVR_W'($urandom_range(13, 400));
        end
        else if (pick < 95)
            c.mode = MODE_CLEAR_OVR;
        else
            c.mode = MODE_W'($urandom_range(5, 7));
        return c;
    endfunction

    task automatic push_cmd(input cmd_t c);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write_t w;
        w.index = idx;
        w.data  = val;
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= w;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_idle(input int tx, input int rx);
        @(posedge clk);
        tx_idle_pct = tx;
        rx_idle_pct = rx;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.payload  = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        status_if.ready = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        set_idle(15, 69);
        push_cmd(make_cmd(MODE_TICK, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(3'd5, 1'b1, 1'b1, 1'b1, 24'hFFFFFF));
        push_cmd(make_cmd(3'd6, 1'b1, 1'b1, 1'b1, 24'h000001));
        push_cmd(make_cmd(3'd7, 1'b0, 1'b1, 1'b0, 24'h800000));
        push_cmd(make_cmd(MODE_START, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_START, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_TICK, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_TICK, 1'b1, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_STOP, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_STOP, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_FORCE, 1'b0, 1'b1, 1'b1, 24'd1));
        push_cmd(make_cmd(MODE_TICK, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_FORCE, 1'b0, 1'b1, 1'b1, 24'd0));
        push_cmd(make_cmd(MODE_START, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_TICK, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_CLEAR_OVR, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_FORCE, 1'b0, 1'b0, 1'b1, 24'hFFFFFF));
        push_cmd(make_cmd(MODE_FORCE, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_START, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_FORCE, 1'b0, 1'b1, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_TICK, 1'b1, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_FORCE, 1'b0, 1'b0, 1'b1, 24'd2));
        push_cmd(make_cmd(MODE_START, 1'b0, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_TICK, 1'b1, 1'b0, 1'b0, 24'd0));
        push_cmd(make_cmd(MODE_TICK, 1'b1, 1'b0, 1'b0, 24'd0));

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(CFG_DEBOUNCE, DEB_TAB[p]);
            write_reg(CFG_HALF_PERIOD, HALF_TAB[p]);
            write_reg(CFG_RING_EN, CFG_DATA_W'(EN_TAB[p]));
            write_reg(CFG_ASSUME_ON, CFG_DATA_W'(ASM_TAB[p]));
            if (p / 2 == 0)
                set_idle(15, 69);
            else if (p / 2 == 1)
                set_idle(69, 15);
            else
                set_idle(0, 0);
            if (p == 0)
                stall_go = 1'b1;
            repeat (PHASE_ITEMS)
                push_cmd(random_cmd());
        end

        drain();
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
